>>> rtl/core/ring_buffer_with_average_drain_defines.svh
// Assertion macros used by the ring buffer checker.
`ifndef RING_BUFFER_WITH_AVERAGE_DRAIN_DEFINES_SVH
`define RING_BUFFER_WITH_AVERAGE_DRAIN_DEFINES_SVH

// Condition and consequence in the same cycle.
`define RBAD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequence in the cycle after the condition.
`define RBAD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/rbad_pkg.sv
// Shared types and codes of the ring buffer with average drain.
`timescale 1ns / 1ps

package rbad_pkg;

   localparam int COUNT_W     = 7;             // entry count, size and fill count
   localparam int MOD_X_W     = COUNT_W + 1;   // operand of the index reduction
   localparam int CMD_W       = 3;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 7;

   localparam logic [COUNT_W-1:0] SIZE_RESET = 7'd64;

   localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_POP   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_AVG   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_SIZE_IN_USE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OVERWRITE   = 2'd1;

   // Divider status seen by the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

>>> rtl/core/rbad_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rbad_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/rbad_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module rbad_div #(
   parameter int DIVIDEND_W = 23,
   parameter int DIVISOR_W  = 7
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [DIVIDEND_W-1:0]      dividend,
   input  logic [DIVISOR_W-1:0]       divisor,
   output logic [DIVIDEND_W-1:0]      quotient,
   output logic [DIVISOR_W-1:0]       remainder,
   output rbad_pkg::div_sts_type      sts
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   // trial stays below twice the divisor, so the difference fits the remainder
   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = (trial >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign sts.busy  = busy_ff;
   assign sts.done  = done_ff;

endmodule

>>> rtl/core/ring_buffer_with_average_drain.sv
// Top level of the ring buffer of signed samples with average drain.
`timescale 1ns / 1ps

// Ring buffer of DEPTH signed samples with push, pop, peek, clear and an
// average-and-drain command; every request beat gives exactly one response
// beat carrying data, status and the fill count after the command. One
// command is in work at a time and req_ready is high only while the
// sequencer is idle; a finished response sits in the output register, so
// the next request is taken while it waits for rsp_ready. A rejected push,
// an empty pop/peek/average, clear and unknown codes go straight to the
// response; a push first reduces its store index, a peek waits for the
// registered read of the sample RAM, and a pop also updates the oldest
// pointer. Average repeats read, accumulate and advance for each held
// entry, then forms sum / count in the shared bit-serial divider. Pointer
// wrap uses a compare and subtract; only when size_in_use has been cut
// below the held pointers does a wrap fall back to the divider. The
// sample RAM is not cleared by reset; reset clears the pointers, the fill
// count, the overwrite flag and rsp_valid, and sets size_in_use to 64.
// Configuration writes (csr_ready always high) must be done while idle.
module ring_buffer_with_average_drain #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [rbad_pkg::CMD_W-1:0]            req_command,
   input  logic signed [DATA_WIDTH-1:0]          req_sample_in,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [DATA_WIDTH-1:0]          rsp_data_out,
   output logic [rbad_pkg::STATUS_W-1:0]         rsp_status,
   output logic [rbad_pkg::COUNT_W-1:0]          rsp_fill_count,
   // configuration write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rbad_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [rbad_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int CW    = rbad_pkg::COUNT_W;
   localparam int MXW   = rbad_pkg::MOD_X_W;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int SUM_W = DATA_WIDTH + CW;   // holds a sum of up to 127 samples

   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_RDISSUE = 7'b0000010,
      S_RDWAIT  = 7'b0000100,
      S_MOD     = 7'b0001000,
      S_DIVMOD  = 7'b0010000,
      S_DIVAVG  = 7'b0100000,
      S_DONE    = 7'b1000000
   } state_type;

   state_type                        state_ff, state_in;
   logic [rbad_pkg::CMD_W-1:0]       cmd_ff, cmd_in;
   logic [DATA_WIDTH-1:0]            smp_ff, smp_in;
   logic [IDX_W-1:0]                 oldest_ff, oldest_in;
   logic [CW-1:0]                    count_ff, count_in;
   logic [CW-1:0]                    size_ff, size_in;
   logic                             ovw_ff, ovw_in;
   logic [DATA_WIDTH-1:0]            res_data_ff, res_data_in;
   logic [rbad_pkg::STATUS_W-1:0]    res_status_ff, res_status_in;
   logic signed [SUM_W-1:0]          sum_ff, sum_in;
   logic [CW-1:0]                    avg_n_ff, avg_n_in;
   logic [MXW-1:0]                   mod_x_ff, mod_x_in;
   logic                             mod_push_ff, mod_push_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0]            rsp_data_ff, rsp_data_in;
   logic [rbad_pkg::STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [CW-1:0]                    rsp_fill_ff, rsp_fill_in;

   // effective ring size: 0 acts as 1, above DEPTH acts as DEPTH
   logic [CW-1:0]          s_eff;
   logic [MXW-1:0]         mod_red;
   logic                   mod_fire;
   logic [CW-1:0]          mod_r;

   logic                   ram_wr_en;
   logic [IDX_W-1:0]       ram_wr_addr;
   logic [DATA_WIDTH-1:0]  ram_wr_data;
   logic                   ram_rd_en;
   logic [DATA_WIDTH-1:0]  ram_rd_data;

   logic                   div_start;
   logic                   div_avg;
   logic [SUM_W-1:0]       div_dividend;
   logic [CW-1:0]          div_divisor;
   logic [SUM_W-1:0]       div_quo;
   logic [CW-1:0]          div_rem;
   rbad_pkg::div_sts_type  div_sts;
   logic [SUM_W-1:0]       abs_sum;
   logic [SUM_W-1:0]       avg_q;

   always_comb begin
      if (size_ff == '0) begin
         s_eff = CW'(1);
      end else if (size_ff > DEPTH_C) begin
         s_eff = DEPTH_C;
      end else begin
         s_eff = size_ff;
      end
   end

   assign mod_red = mod_x_ff - MXW'(s_eff);

   // sign and magnitude around the unsigned divider; quotient truncates to zero
   assign abs_sum      = sum_ff[SUM_W-1] ? unsigned'(-sum_ff) : unsigned'(sum_ff);
   assign avg_q        = sum_ff[SUM_W-1] ? (~div_quo + SUM_W'(1)) : div_quo;
   assign div_dividend = div_avg ? abs_sum : SUM_W'(mod_x_ff);
   assign div_divisor  = div_avg ? avg_n_ff : s_eff;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      smp_in        = smp_ff;
      oldest_in     = oldest_ff;
      count_in      = count_ff;
      size_in       = size_ff;
      ovw_in        = ovw_ff;
      res_data_in   = res_data_ff;
      res_status_in = res_status_ff;
      sum_in        = sum_ff;
      avg_n_in      = avg_n_ff;
      mod_x_in      = mod_x_ff;
      mod_push_in   = mod_push_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_fill_in   = rsp_fill_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = oldest_ff;
      ram_wr_data   = smp_ff;
      ram_rd_en     = 1'b0;
      div_start     = 1'b0;
      div_avg       = 1'b0;
      mod_fire      = 1'b0;
      mod_r         = '0;

      if (csr_valid) begin
         case (csr_index)
            rbad_pkg::CSR_SIZE_IN_USE: size_in = csr_wdata[CW-1:0];
            rbad_pkg::CSR_OVERWRITE:   ovw_in  = csr_wdata[0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in        = req_command;
               smp_in        = req_sample_in;
               res_data_in   = '0;
               res_status_in = rbad_pkg::ST_OK;
               state_in      = S_DONE;
               case (req_command)
                  rbad_pkg::CMD_PUSH: begin
                     if (count_ff < s_eff) begin
                        mod_x_in    = MXW'(count_ff) + MXW'(oldest_ff);
                        mod_push_in = 1'b1;
                        state_in    = S_MOD;
                     end else if (ovw_ff) begin
                        // full: replace oldest, then advance it
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = oldest_ff;
                        ram_wr_data = req_sample_in;
                        mod_x_in    = MXW'(oldest_ff) + MXW'(1);
                        mod_push_in = 1'b0;
                        state_in    = S_MOD;
                     end else begin
                        res_status_in = rbad_pkg::ST_FULL;
                     end
                  end
                  rbad_pkg::CMD_POP, rbad_pkg::CMD_PEEK: begin
                     if (count_ff == '0) begin
                        res_status_in = rbad_pkg::ST_EMPTY;
                     end else begin
                        state_in = S_RDISSUE;
                     end
                  end
                  rbad_pkg::CMD_AVG: begin
                     if (count_ff == '0) begin
                        res_data_in   = '1;
                        res_status_in = rbad_pkg::ST_EMPTY;
                     end else begin
                        sum_in   = '0;
                        avg_n_in = count_ff;
                        state_in = S_RDISSUE;
                     end
                  end
                  rbad_pkg::CMD_CLEAR: begin
                     count_in  = '0;
                     oldest_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         S_RDISSUE: begin
            ram_rd_en = 1'b1;
            state_in  = S_RDWAIT;
         end
         S_RDWAIT: begin
            case (cmd_ff)
               rbad_pkg::CMD_PEEK: begin
                  res_data_in = ram_rd_data;
                  state_in    = S_DONE;
               end
               rbad_pkg::CMD_POP: begin
                  res_data_in = ram_rd_data;
                  count_in    = count_ff - CW'(1);
                  mod_x_in    = MXW'(oldest_ff) + MXW'(1);
                  mod_push_in = 1'b0;
                  state_in    = S_MOD;
               end
               default: begin
                  // average drain: accumulate and pop
                  sum_in      = sum_ff + SUM_W'($signed(ram_rd_data));
                  count_in    = count_ff - CW'(1);
                  mod_x_in    = MXW'(oldest_ff) + MXW'(1);
                  mod_push_in = 1'b0;
                  state_in    = S_MOD;
               end
            endcase
         end
         S_MOD: begin
            // below twice the size a compare and subtract wraps the index
            if (mod_x_ff < MXW'(s_eff)) begin
               mod_fire = 1'b1;
               mod_r    = mod_x_ff[CW-1:0];
            end else if (mod_red < MXW'(s_eff)) begin
               mod_fire = 1'b1;
               mod_r    = mod_red[CW-1:0];
            end else begin
               div_start = 1'b1;
               state_in  = S_DIVMOD;
            end
         end
         S_DIVMOD: begin
            if (div_sts.done) begin
               mod_fire = 1'b1;
               mod_r    = div_rem;
            end
         end
         S_DIVAVG: begin
            div_avg = 1'b1;
            if (div_sts.done) begin
               res_data_in = avg_q[DATA_WIDTH-1:0];
               state_in    = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = res_data_ff;
               rsp_status_in = res_status_ff;
               rsp_fill_in   = count_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // commit of a reduced index: store slot of a push, or new oldest
      if (mod_fire) begin
         if (mod_push_ff) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = mod_r[IDX_W-1:0];
            ram_wr_data = smp_ff;
            count_in    = count_ff + CW'(1);
            state_in    = S_DONE;
         end else begin
            oldest_in = mod_r[IDX_W-1:0];
            if (cmd_ff == rbad_pkg::CMD_AVG) begin
               if (count_ff != '0) begin
                  state_in = S_RDISSUE;
               end else begin
                  div_start = 1'b1;
                  div_avg   = 1'b1;
                  state_in  = S_DIVAVG;
               end
            end else begin
               state_in = S_DONE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         oldest_ff    <= '0;
         count_ff     <= '0;
         size_ff      <= rbad_pkg::SIZE_RESET;
         ovw_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         oldest_ff    <= oldest_in;
         count_ff     <= count_in;
         size_ff      <= size_in;
         ovw_ff       <= ovw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      smp_ff        <= smp_in;
      res_data_ff   <= res_data_in;
      res_status_ff <= res_status_in;
      sum_ff        <= sum_in;
      avg_n_ff      <= avg_n_in;
      mod_x_ff      <= mod_x_in;
      mod_push_ff   <= mod_push_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

   rbad_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (oldest_ff),
      .rd_data (ram_rd_data)
   );

   rbad_div #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (CW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quo),
      .remainder (div_rem),
      .sts       (div_sts)
   );

   assign req_ready      = (state_ff == S_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data_out   = rsp_data_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_fill_count = rsp_fill_ff;

endmodule

>>> rtl/core/rbad_checker.sv
// Port-level assertions for the ring buffer, bound to the top level.
`timescale 1ns / 1ps
`include "ring_buffer_with_average_drain_defines.svh"

module rbad_checker #(
   parameter int DEPTH = 64
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [rbad_pkg::STATUS_W-1:0]     rsp_status,
   input logic [rbad_pkg::COUNT_W-1:0]      rsp_fill_count
);

   // a response beat is held until taken
   `RBAD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped")

   // the ring never holds more than its depth
   `RBAD_ASSERT_NOW(a_fill_range, clock, reset, rsp_valid, rsp_fill_count <= DEPTH, "fill overflow")

   // empty status only with nothing held
   `RBAD_ASSERT_NOW(a_empty_fill, clock, reset, rsp_valid && rsp_status == rbad_pkg::ST_EMPTY, rsp_fill_count == '0, "empty with entries")

   // a rejected push means the ring holds entries
   `RBAD_ASSERT_NOW(a_full_fill, clock, reset, rsp_valid && rsp_status == rbad_pkg::ST_FULL, rsp_fill_count != '0, "full with no entries")

endmodule

bind ring_buffer_with_average_drain rbad_checker #(
   .DEPTH (DEPTH)
) u_rbad_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_status     (rsp_status),
   .rsp_fill_count (rsp_fill_count)
);
